### rtl/lsbse_pkg.sv
package lsbse_pkg;

    localparam int MAGIC_W = 16;
    localparam int HDR_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int FIELD_W = 32;
    localparam int BITS_W  = 5;

    localparam logic [HDR_W-1:0] HDR_BYTES_RST = 10'd54;

    // bit count limits: field width minus one
    localparam logic [BITS_W-1:0] LAST_BIT_MAGIC = 5'd15;
    localparam logic [BITS_W-1:0] LAST_BIT_LEN   = 5'd31;
    localparam logic [BITS_W-1:0] LAST_BIT_BYTE  = 5'd7;

    localparam logic [KIND_W-1:0] KIND_EXT       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SECRET    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_MAGIC = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXT_LONG  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;

    localparam logic CFG_MAGIC  = 1'b0;
    localparam logic CFG_HEADER = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

endpackage

### rtl/lsbse_parser.sv
module lsbse_parser #(
    parameter int MAX_EXT_CHARS = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [lsbse_pkg::BYTE_W-1:0]  i_image_byte,
    input  logic                          i_start_of_file,
    input  logic [lsbse_pkg::MAGIC_W-1:0] i_magic_word,
    input  logic [lsbse_pkg::HDR_W-1:0]   i_header_bytes,
    output lsbse_pkg::t_result            o_result
);
    import lsbse_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MAGIC,
        PH_EXT_LEN,
        PH_EXT,
        PH_SEC_LEN,
        PH_SEC,
        PH_STOP
    } t_phase;

    localparam logic [FIELD_W-1:0] MAX_EXT = FIELD_W'(MAX_EXT_CHARS);

    t_phase               r_phase, n_phase, c_phase;
    logic [HDR_W-1:0]     r_hdr, n_hdr, c_hdr;
    logic [BITS_W-1:0]    r_bits, n_bits, c_bits, lim;
    logic [FIELD_W-1:0]   r_shift, n_shift, c_shift, shifted;
    logic [FIELD_W-1:0]   r_rem, n_rem, c_rem, rem_dec;
    logic                 done;
    t_result              res;

    always_comb begin
        // start of file restarts the parse on this very byte
        c_phase = i_start_of_file ? PH_HEADER : r_phase;
        c_hdr   = i_start_of_file ? '0 : r_hdr;
        c_bits  = i_start_of_file ? '0 : r_bits;
        c_shift = i_start_of_file ? '0 : r_shift;
        c_rem   = i_start_of_file ? '0 : r_rem;

        if (c_phase == PH_HEADER && c_hdr >= i_header_bytes) begin
            c_phase = PH_MAGIC;
            c_bits  = '0;
            c_shift = '0;
        end

        unique case (c_phase)
            PH_MAGIC:               lim = LAST_BIT_MAGIC;
            PH_EXT_LEN, PH_SEC_LEN: lim = LAST_BIT_LEN;
            default:                lim = LAST_BIT_BYTE;
        endcase

        shifted = {c_shift[FIELD_W-2:0], i_image_byte[0]};
        done    = (c_bits == lim);
        rem_dec = c_rem - FIELD_W'(1);

        n_phase = c_phase;
        n_hdr   = c_hdr;
        n_bits  = done ? '0 : c_bits + BITS_W'(1);
        n_shift = shifted;
        n_rem   = c_rem;
        res     = '0;

        unique case (c_phase)
            PH_HEADER: begin
                n_hdr   = c_hdr + HDR_W'(1);
                n_bits  = c_bits;
                n_shift = c_shift;
            end
            PH_MAGIC: begin
                if (done) begin
                    n_shift = '0;
                    if (shifted[MAGIC_W-1:0] != i_magic_word) begin
                        n_phase = PH_STOP;
                        res     = '{valid: 1'b1, kind: KIND_BAD_MAGIC, value: '0, last: 1'b1};
                    end else begin
                        n_phase = PH_EXT_LEN;
                    end
                end
            end
            PH_EXT_LEN: begin
                if (done) begin
                    n_shift = '0;
                    n_rem   = shifted;
                    if (shifted > MAX_EXT) begin
                        n_phase = PH_STOP;
                        res     = '{valid: 1'b1, kind: KIND_EXT_LONG, value: '0, last: 1'b1};
                    end else begin
                        n_phase = (shifted == '0) ? PH_SEC_LEN : PH_EXT;
                    end
                end
            end
            PH_EXT: begin
                if (done) begin
                    n_shift = '0;
                    n_rem   = rem_dec;
                    n_phase = (rem_dec == '0) ? PH_SEC_LEN : PH_EXT;
                    res     = '{valid: 1'b1, kind: KIND_EXT,
                                value: shifted[BYTE_W-1:0], last: 1'b0};
                end
            end
            PH_SEC_LEN: begin
                if (done) begin
                    n_shift = '0;
                    n_rem   = shifted;
                    if (shifted == '0) begin
                        n_phase = PH_STOP;
                        res     = '{valid: 1'b1, kind: KIND_EMPTY, value: '0, last: 1'b1};
                    end else begin
                        n_phase = PH_SEC;
                    end
                end
            end
            PH_SEC: begin
                if (done) begin
                    n_shift = '0;
                    n_rem   = rem_dec;
                    n_phase = (rem_dec == '0) ? PH_STOP : PH_SEC;
                    res     = '{valid: 1'b1, kind: KIND_SECRET,
                                value: shifted[BYTE_W-1:0], last: (rem_dec == '0)};
                end
            end
            default: begin
                n_bits  = c_bits;
                n_shift = c_shift;
            end
        endcase

        if (!i_advance) begin
            res.valid = 1'b0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hdr   <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_rem   <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_rem   <= n_rem;
        end
    end

endmodule

### rtl/lsbse_out_reg.sv
module lsbse_out_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  lsbse_pkg::t_result           i_result,
    input  logic                         i_stall,
    output logic                         o_free,
    output logic                         o_valid,
    output logic [lsbse_pkg::KIND_W-1:0] o_kind,
    output logic [lsbse_pkg::BYTE_W-1:0] o_value,
    output logic                         o_last
);
    import lsbse_pkg::*;

    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_value;
    logic              r_last;

    // slot frees up in the same cycle the held word is taken
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_kind  <= i_result.kind;
            r_value <= i_result.value;
            r_last  <= i_result.last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

### rtl/lsb_stego_stream_extractor_unit.sv
// an accepted byte waits in the input register until the output slot is free, then its result word is registered
// throughput: one file byte per cycle while the output slot is free, at most one result word per byte
// the input register refills in the same cycle its byte moves on to the parser
// reset: synchronous active low, clears parse state and both register stages,
// magic word returns to zero and header length to 54
module lsb_stego_stream_extractor_unit #(
    parameter int MAX_EXT_CHARS = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lsbse_pkg::BYTE_W-1:0]  i_image_byte,
    input  logic                          i_start_of_file,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lsbse_pkg::KIND_W-1:0]  o_kind,
    output logic [lsbse_pkg::BYTE_W-1:0]  o_value,
    output logic                          o_last_of_file,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [lsbse_pkg::MAGIC_W-1:0] i_cfg_data
);
    import lsbse_pkg::*;

    logic [MAGIC_W-1:0] r_magic_word;
    logic [HDR_W-1:0]   r_header_bytes;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_sof;
    logic               out_free;
    logic               advance;
    logic               accept;
    t_result            result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word   <= '0;
            r_header_bytes <= HDR_BYTES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAGIC:  r_magic_word   <= i_cfg_data;
                CFG_HEADER: r_header_bytes <= i_cfg_data[HDR_W-1:0];
                default:    r_magic_word   <= r_magic_word;
            endcase
        end
    end

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_image_byte;
            r_in_sof  <= i_start_of_file;
        end
    end

    lsbse_parser #(
        .MAX_EXT_CHARS(MAX_EXT_CHARS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_image_byte   (r_in_byte),
        .i_start_of_file(r_in_sof),
        .i_magic_word   (r_magic_word),
        .i_header_bytes (r_header_bytes),
        .o_result       (result)
    );

    lsbse_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_result(result),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_kind  (o_kind),
        .o_value (o_value),
        .o_last  (o_last_of_file)
    );

    // error and end markers always close the file
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_BAD_MAGIC || o_kind == KIND_EXT_LONG ||
                         o_kind == KIND_EMPTY)) |-> (o_last_of_file && o_value == '0))
        else $error("marker word without last flag or with nonzero value");

    a_ext_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_EXT) |-> !o_last_of_file)
        else $error("extension character flagged as last");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_EXT || o_kind == KIND_SECRET ||
                         o_kind == KIND_BAD_MAGIC || o_kind == KIND_EXT_LONG ||
                         o_kind == KIND_EMPTY))
        else $error("result kind out of range");

    a_no_advance_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && $past(o_out_valid)) |-> o_out_valid)
        else $error("input stalled while output slot empty");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lsbse_pkg::*;

    localparam int EXT_CHAR_LIMIT = 9;
    localparam int RANDOM_BYTES   = 1150;
    localparam int LATENCY_PAD    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CUT_NONE       = -1;
    localparam int CUT_RANDOM     = -2;
    localparam int RANDOM_FILL    = -1;

    typedef enum logic [2:0] {
        PH_HEADER, PH_MAGIC, PH_EXT_LEN, PH_EXT, PH_SEC_LEN, PH_SEC, PH_STOP
    } t_parse_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_decoded;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              sof;
    } t_file_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_image_byte = '0;
    logic                  i_start_of_file = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [BYTE_W-1:0]     o_value;
    logic                  o_last_of_file;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = CFG_MAGIC;
    logic [MAGIC_W-1:0]    i_cfg_data = '0;

    lsb_stego_stream_extractor_unit #(
        .MAX_EXT_CHARS(EXT_CHAR_LIMIT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_image_byte    (i_image_byte),
        .i_start_of_file (i_start_of_file),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_value         (o_value),
        .o_last_of_file  (o_last_of_file),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // register copies and parse state of the decoder model
    logic [MAGIC_W-1:0] cfg_magic = '0;
    logic [HDR_W-1:0]   cfg_header = HDR_BYTES_RST;
    t_parse_phase       parse_phase = PH_HEADER;
    logic [HDR_W-1:0]   skipped = '0;
    logic [BITS_W-1:0]  bit_idx = '0;
    logic [FIELD_W-1:0] gathered = '0;
    logic [FIELD_W-1:0] chars_left = '0;

    t_file_byte file_bytes[$];
    t_decoded   expected_words[$];
    logic       frame_bits[$];

    int   fail_count = 0;
    int   data_bytes = 0;
    logic byte_taken = 1'b0;
    logic hold_wanted = 1'b0;
    int   hold_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_seg = 0;
    int   stall_pct = 0;
    int   idle_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic emit_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] value,
                             input logic last);
        t_decoded w;
        w.kind  = kind;
        w.value = value;
        w.last  = last;
        expected_words.push_back(w);
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] data, input logic sof);
        logic [BITS_W-1:0] final_bit;
        if (sof) begin
            parse_phase = PH_HEADER;
            skipped     = '0;
            bit_idx     = '0;
            gathered    = '0;
            chars_left  = '0;
        end
        if (parse_phase == PH_HEADER) begin
            if (skipped < cfg_header) begin
                skipped++;
                return;
            end
            parse_phase = PH_MAGIC;
            bit_idx     = '0;
            gathered    = '0;
        end
        if (parse_phase == PH_STOP)
            return;
        case (parse_phase)
            PH_MAGIC:               final_bit = LAST_BIT_MAGIC;
            PH_EXT_LEN, PH_SEC_LEN: final_bit = LAST_BIT_LEN;
            default:                final_bit = LAST_BIT_BYTE;
        endcase
        gathered = {gathered[FIELD_W-2:0], data[0]};
        if (bit_idx != final_bit) begin
            bit_idx++;
            return;
        end
        bit_idx = '0;
        case (parse_phase)
            PH_MAGIC: begin
                if (gathered[MAGIC_W-1:0] != cfg_magic) begin
                    parse_phase = PH_STOP;
                    emit_word(KIND_BAD_MAGIC, '0, 1'b1);
                end else begin
                    parse_phase = PH_EXT_LEN;
                    gathered    = '0;
                end
            end
            PH_EXT_LEN: begin
                chars_left = gathered;
                if (chars_left > EXT_CHAR_LIMIT) begin
                    parse_phase = PH_STOP;
                    emit_word(KIND_EXT_LONG, '0, 1'b1);
                end else begin
                    parse_phase = (chars_left == 0) ? PH_SEC_LEN : PH_EXT;
                    gathered    = '0;
                end
            end
            PH_EXT: begin
                chars_left--;
                emit_word(KIND_EXT, gathered[BYTE_W-1:0], 1'b0);
                parse_phase = (chars_left == 0) ? PH_SEC_LEN : PH_EXT;
                gathered    = '0;
            end
            PH_SEC_LEN: begin
                chars_left = gathered;
                if (chars_left == 0) begin
                    parse_phase = PH_STOP;
                    emit_word(KIND_EMPTY, '0, 1'b1);
                end else begin
                    parse_phase = PH_SEC;
                    gathered    = '0;
                end
            end
            PH_SEC: begin
                chars_left--;
                if (chars_left == 0) begin
                    parse_phase = PH_STOP;
                    emit_word(KIND_SECRET, gathered[BYTE_W-1:0], 1'b1);
                end else begin
                    emit_word(KIND_SECRET, gathered[BYTE_W-1:0], 1'b0);
                    gathered = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_field(input logic [FIELD_W-1:0] v, input int width);
        for (int i = width - 1; i >= 0; i--)
            frame_bits.push_back(v[i]);
    endtask

    function automatic logic [BYTE_W-1:0] fill_byte(input int pattern, input int k);
        if (pattern < 0)
            return BYTE_W'($urandom_range(0, 255));
        return k[0] ? ~pattern[BYTE_W-1:0] : pattern[BYTE_W-1:0];
    endfunction

    // one stego file: header bytes, then hidden fields in bit 0, then trailing junk
    task automatic queue_file(input logic sof_mark, input int hdr, input logic [15:0] magic,
                              input logic [31:0] ext_len, input int n_ext,
                              input logic [31:0] sec_len, input int n_sec,
                              input int cut, input int junk, input int pattern);
        int         keep;
        t_file_byte w;
        frame_bits.delete();
        add_field(FIELD_W'(magic), MAGIC_W);
        add_field(ext_len, FIELD_W);
        for (int i = 0; i < n_ext; i++)
            add_field(FIELD_W'(fill_byte(pattern, i)), BYTE_W);
        add_field(sec_len, FIELD_W);
        for (int i = 0; i < n_sec; i++)
            add_field(FIELD_W'(fill_byte(pattern, i)), BYTE_W);
        keep = frame_bits.size();
        if (cut == CUT_RANDOM)
            keep = $urandom_range(0, keep - 1);
        else if (cut >= 0 && cut < keep)
            keep = cut;
        for (int i = 0; i < hdr + keep + junk; i++) begin
            w.data = BYTE_W'($urandom_range(0, 255));
            if (i >= hdr && i < hdr + keep)
                w.data[0] = frame_bits[i-hdr];
            w.sof = sof_mark && (i == 0);
            file_bytes.push_back(w);
        end
        data_bytes += hdr + keep + junk;
    endtask

    task automatic write_reg(input logic idx, input logic [MAGIC_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_MAGIC)
            cfg_magic = data;
        else
            cfg_header = data[HDR_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (file_bytes.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    // byte driver: bursts with random gaps, word held until taken
    always @(negedge i_clk) begin : drive_bytes
        t_file_byte w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !byte_taken) begin
            // stalled word stays put
        end else if (gap_left != 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (file_bytes.size() != 0) begin
            w = file_bytes.pop_front();
            i_image_byte    <= w.data;
            i_start_of_file <= w.sof;
            i_in_valid      <= 1'b1;
            if (burst_left != 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 60);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        byte_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            decode_byte(i_image_byte, i_start_of_file);
    end

    // receiver stall: segments with their own stall rate, plus one long hold
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_wanted && hold_count < HOLD_CYCLES) begin
            hold_count++;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_seg == 0) begin
                stall_seg = $urandom_range(5, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end else begin
                stall_seg--;
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_words
        t_decoded want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: kind %0d value %0h last %0b",
                       o_kind, o_value, o_last_of_file);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                    fail_count++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %0h, actual %0h", want.value, o_value);
                    fail_count++;
                end
                if (o_last_of_file !== want.last) begin
                    $error("last_of_file: expected %0b, actual %0b", want.last, o_last_of_file);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int            phase_no;
        int            n_files;
        int            pick;
        int            hdr;
        logic [15:0]   magic;
        logic [31:0]   ext_len;
        logic [31:0]   sec_len;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, no start mark on the first file
        queue_file(1'b0, 54, 16'h0000, 0, 0, 1, 1, CUT_NONE, 3, 'hFF);
        wait_drained();
        write_reg(CFG_MAGIC, 16'h4D42);
        write_reg(CFG_HEADER, 16'd0);
        queue_file(1'b1, 0, 16'h4D42, EXT_CHAR_LIMIT, EXT_CHAR_LIMIT, 2, 2, CUT_NONE, 2, 'h00);
        queue_file(1'b1, 0, 16'h4D43, 0, 0, 1, 1, CUT_NONE, 5, RANDOM_FILL);
        queue_file(1'b1, 0, 16'h4D42, EXT_CHAR_LIMIT + 1, 0, 1, 1, CUT_NONE, 0, RANDOM_FILL);
        queue_file(1'b1, 0, 16'h4D42, 32'h8000_0000, 0, 1, 1, CUT_NONE, 0, RANDOM_FILL);
        queue_file(1'b1, 0, 16'h4D42, 0, 0, 0, 0, CUT_NONE, 2, RANDOM_FILL);
        // huge secret cut short by the next start of file
        queue_file(1'b1, 0, 16'h4D42, 1, 1, 32'hFFFF_FFFF, 3, CUT_NONE, 0, 'hA5);
        wait_drained();
        // shorten the header while the parse sits in the skip
        write_reg(CFG_HEADER, 16'd20);
        queue_file(1'b1, 8, 16'h0000, 0, 0, 0, 0, 0, 0, RANDOM_FILL);
        wait_drained();
        write_reg(CFG_HEADER, 16'd3);
        queue_file(1'b0, 0, 16'h4D42, 1, 1, 1, 1, CUT_NONE, 0, 'h5A);
        wait_drained();

        phase_no = 0;
        while (data_bytes < RANDOM_BYTES) begin
            case (phase_no)
                0: begin magic = 16'hFFFF; hdr = 0; n_files = 1; end
                default: begin
                    magic   = 16'($urandom_range(0, 16'hFFFF));
                    hdr     = $urandom_range(0, 12);
                    n_files = $urandom_range(2, 5);
                end
            endcase
            write_reg(CFG_MAGIC, magic);
            write_reg(CFG_HEADER, MAGIC_W'(hdr));
            if (phase_no == 0)
                hold_wanted = 1'b1;
            for (int f = 0; f < n_files && data_bytes < RANDOM_BYTES; f++) begin
                pick    = $urandom_range(0, 99);
                ext_len = $urandom_range(0, EXT_CHAR_LIMIT);
                sec_len = $urandom_range(1, 10);
                if (pick < 70 || phase_no == 0) begin
                    queue_file($urandom_range(0, 19) != 0, hdr, magic, ext_len, ext_len,
                               sec_len, sec_len, CUT_NONE, $urandom_range(0, 4), RANDOM_FILL);
                end else if (pick < 78) begin
                    queue_file(1'b1, hdr, magic ^ (16'h1 << $urandom_range(0, 15)), ext_len,
                               ext_len, sec_len, sec_len, CUT_NONE, $urandom_range(0, 4),
                               RANDOM_FILL);
                end else if (pick < 84) begin
                    ext_len = $urandom;
                    if (ext_len <= EXT_CHAR_LIMIT)
                        ext_len = ext_len | 32'h8000_0000;
                    if ($urandom_range(0, 1) == 0)
                        ext_len = $urandom_range(EXT_CHAR_LIMIT + 1, 300);
                    queue_file(1'b1, hdr, magic, ext_len, 0, sec_len, 1, CUT_NONE,
                               $urandom_range(0, 4), RANDOM_FILL);
                end else if (pick < 89) begin
                    queue_file(1'b1, hdr, magic, ext_len, ext_len, 0, 0, CUT_NONE,
                               $urandom_range(0, 4), RANDOM_FILL);
                end else begin
                    queue_file(1'b1, hdr, magic, ext_len, ext_len, sec_len, sec_len,
                               CUT_RANDOM, 0, RANDOM_FILL);
                end
            end
            wait_drained();
            phase_no++;
        end

        wait_drained();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
